// ----- rtl/cfr_pkg.sv -----
// Package for the continued-fraction ratio unit.
// Holds default widths, register codes, controller states and the command and
// status structs shared by the controller, the datapath and the top level.
package cfr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS_DEF  = 32;
  localparam int RATIO_W       = 32;
  localparam int TOL_W         = 16;
  localparam int MAXR_W        = 4;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MAX_REFS  = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd1;
  localparam logic [MAXR_W-1:0] MAXR_RESET = 4'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_START,
    S_RD_MUL,
    S_ROUND,
    S_CHECK,
    S_DIV,
    S_DA_START,
    S_DA_MUL,
    S_UPDATE,
    S_FINISH
  } cfr_state_e;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic mul_step;
    logic round;
    logic div_start;
    logic div_step;
    logic da_start;
    logic update;
  } cfr_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic close;
    logic f_small;
    logic sat;
  } cfr_stat_t;

endpackage

// ----- rtl/cfr_datapath.sv -----
// Datapath of the continued-fraction ratio unit: shift-add multiplier,
// restoring divider and the N/D recurrence registers. Uses cfr_pkg.
module cfr_datapath import cfr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OUT_BITS  = OUT_BITS_DEF
) (
  input  logic                 clk_i,
  input  cfr_cmd_t             cmd_i,
  input  logic [RATIO_W-1:0]   ratio_i,
  input  logic [TOL_W-1:0]     tol_i,
  output cfr_stat_t            stat_o,
  output logic [OUT_BITS-1:0]  numer_o,
  output logic [OUT_BITS-1:0]  denom_o,
  output logic                 sat_o
);

  localparam int PW  = RATIO_W + OUT_BITS;
  localparam int MPW = (OUT_BITS > FRAC_BITS + 1) ? OUT_BITS : FRAC_BITS + 1;
  localparam int QB  = 2 * FRAC_BITS + 1;
  localparam int CW  = $clog2(QB + 1);
  localparam int FTW = (FRAC_BITS > TOL_W) ? FRAC_BITS : TOL_W;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;
  localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic [RATIO_W-1:0]   r_q;
  logic [FRAC_BITS-1:0] f_q;
  logic [OUT_BITS-1:0]  d_q, dp_q, n_q;
  logic                 sat_q;
  logic [PW-1:0]        acc_q, mc_q, tacc_q, tmc_q;
  logic [MPW-1:0]       mp_q;
  logic [FRAC_BITS-1:0] rem_q;
  logic [QB-1:0]        quo_q;
  logic [CW-1:0]        cnt_q;

  logic [PW:0]          rnd_sum;
  logic                 rnd_ovf;
  logic [PW-1:0]        nsh, diff;
  logic [FRAC_BITS:0]   rem_sh;
  logic                 rem_ge;

  assign rnd_sum = {1'b0, acc_q} + HALF;
  assign rnd_ovf = |rnd_sum[PW:FRAC_BITS+OUT_BITS];
  assign nsh     = {{(PW-OUT_BITS){1'b0}}, n_q} << FRAC_BITS;
  assign diff    = (acc_q >= nsh) ? (acc_q - nsh) : (nsh - acc_q);
  assign rem_sh  = {rem_q, (cnt_q == '0)};
  assign rem_ge  = rem_sh >= {1'b0, f_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= ratio_i;
      f_q   <= ratio_i[FRAC_BITS-1:0];
      d_q   <= {{(OUT_BITS-1){1'b0}}, 1'b1};
      dp_q  <= '0;
      sat_q <= 1'b0;
    end
    if (cmd_i.rd_start) begin
      acc_q  <= '0;
      tacc_q <= '0;
      mc_q   <= PW'(r_q);
      tmc_q  <= PW'(tol_i);
      mp_q   <= MPW'(d_q);
    end
    if (cmd_i.mul_step) begin
      if (mp_q[0]) begin
        acc_q  <= acc_q + mc_q;
        tacc_q <= tacc_q + tmc_q;
      end
      mc_q  <= mc_q << 1;
      tmc_q <= tmc_q << 1;
      mp_q  <= mp_q >> 1;
    end
    if (cmd_i.round) begin
      if (rnd_ovf) begin
        n_q   <= OUT_MAX;
        sat_q <= 1'b1;
      end else begin
        n_q <= rnd_sum[FRAC_BITS+OUT_BITS-1:FRAC_BITS];
      end
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? FRAC_BITS'(rem_sh - {1'b0, f_q}) : rem_sh[FRAC_BITS-1:0];
      quo_q <= {quo_q[QB-2:0], rem_ge};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.da_start) begin
      // next partial quotient is the integer part, the fraction carries on
      acc_q <= PW'(dp_q);
      mc_q  <= PW'(d_q);
      mp_q  <= MPW'(quo_q[QB-1:FRAC_BITS]);
      f_q   <= quo_q[FRAC_BITS-1:0];
    end
    if (cmd_i.update) begin
      dp_q <= d_q;
      if (|acc_q[PW-1:OUT_BITS]) begin
        d_q   <= OUT_MAX;
        sat_q <= 1'b1;
      end else begin
        d_q <= acc_q[OUT_BITS-1:0];
      end
    end
  end

  assign stat_o.mul_done = (mp_q == '0);
  assign stat_o.div_done = (cnt_q == CW'(QB));
  assign stat_o.close    = (diff <= tacc_q);
  assign stat_o.f_small  = (FTW'(f_q) <= FTW'(tol_i)) || (f_q == '0);
  assign stat_o.sat      = sat_q;

  assign numer_o = n_q;
  assign denom_o = d_q;
  assign sat_o   = sat_q;

endmodule

// ----- rtl/cfr_controller.sv -----
// Sequencer of the continued-fraction ratio unit.
// Issues datapath commands from cfr_pkg and counts refinement steps.
module cfr_controller import cfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  logic [MAXR_W-1:0] max_refs_i,
  input  cfr_stat_t         stat_i,
  output cfr_cmd_t          cmd_o,
  output logic              in_ready_o,
  output logic              out_load_o
);

  cfr_state_e        state_q, state_d;
  logic [MAXR_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_RD_START;
        end
      end
      S_RD_START: begin
        cmd_o.rd_start = 1'b1;
        state_d        = S_RD_MUL;
      end
      S_RD_MUL: begin
        if (stat_i.mul_done) begin
          state_d = S_ROUND;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (step_q >= max_refs_i || stat_i.sat || stat_i.close || stat_i.f_small) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          step_d          = step_q + MAXR_W'(1);
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_DA_START;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DA_START: begin
        cmd_o.da_start = 1'b1;
        state_d        = S_DA_MUL;
      end
      S_DA_MUL: begin
        if (stat_i.mul_done) begin
          state_d = S_UPDATE;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_RD_START;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (out_free_i) begin
          out_load_o = 1'b1;
          step_d     = '0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q <= max_refs_i && step_q != '0))
    else $error("refinement count out of range during division");

endmodule

// ----- rtl/continued_fraction_ratio_unit.sv -----
// Top level of the continued-fraction ratio unit: APB registers, output
// register, controller and datapath. Uses cfr_pkg, cfr_controller, cfr_datapath.
//
// Approximates an unsigned fixed-point ratio (FRAC_BITS fraction bits) by a
// fraction numer/denom through a continued-fraction expansion. The first guess
// is denom = 1, numer = round(ratio), halves up; each refinement takes the
// reciprocal of the fractional part and updates denom = denom*a + previous
// denom, numer = round(ratio*denom). It stops when |ratio - numer/denom| is
// within tolerance, when the fraction is within tolerance, after
// max_refinements steps, or when a value clips to OUT_BITS bits (saturated
// set). One item is in work at a time. Each item is accepted in the idle
// state; then for the first guess and after every refinement a serial
// multiply steps over the significant bits of denom (at most OUT_BITS),
// then the product is rounded and the stop conditions are checked; each
// refinement adds a restoring division over 2*FRAC_BITS+1 quotient bits and
// a multiply over the bits of the partial quotient (at most FRAC_BITS+1),
// and a finish state hands the result to the output register. The output
// register lets a new beat be accepted while the last result still waits.
// Registers: tolerance at address 0, max_refinements at address 4; pready
// is always high.
module continued_fraction_ratio_unit import cfr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OUT_BITS  = OUT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RATIO_W-1:0]  ratio_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_BITS-1:0] numer_o,
  output logic [OUT_BITS-1:0] denom_o,
  output logic                saturated_o
);

  logic [TOL_W-1:0]    tol_q;
  logic [MAXR_W-1:0]   maxr_q;
  logic                out_valid_q;
  logic [OUT_BITS-1:0] numer_q, denom_q;
  logic                sat_q;

  cfr_cmd_t            cmd;
  cfr_stat_t           stat;
  logic                out_load, out_free;
  logic [OUT_BITS-1:0] dp_numer, dp_denom;
  logic                dp_sat;

  // Register file: written on the access phase, read back as a plain mux.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      maxr_q <= MAXR_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TOLERANCE: tol_q  <= pwdata[TOL_W-1:0];
        REG_MAX_REFS:  maxr_q <= pwdata[MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOLERANCE: prdata = APB_DW'(tol_q);
      REG_MAX_REFS:  prdata = APB_DW'(maxr_q);
      default:       prdata = '0;
    endcase
  end

  // Output register: free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      numer_q <= dp_numer;
      denom_q <= dp_denom;
      sat_q   <= dp_sat;
    end
  end

  cfr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .max_refs_i (maxr_q),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load)
  );

  cfr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .ratio_i (ratio_value_i),
    .tol_i   (tol_q),
    .stat_o  (stat),
    .numer_o (dp_numer),
    .denom_o (dp_denom),
    .sat_o   (dp_sat)
  );

  assign out_valid_o = out_valid_q;
  assign numer_o     = numer_q;
  assign denom_o     = denom_q;
  assign saturated_o = sat_q;

  a_denom_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (denom_o != '0))
    else $error("result beat with zero denominator");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while one is in work");

endmodule
